>>> design/rds_pkg.sv
`default_nettype none
package rds_pkg;
  localparam int unsigned CoefFrac = 12;
  // concentration width, Q1.(ValueBits-1)
  localparam int unsigned ValueBits = 16;

  // register indexes
  localparam logic [2:0] RegWidth  = 3'd0;
  localparam logic [2:0] RegHeight = 3'd1;
  localparam logic [2:0] RegAlpha  = 3'd2;
  localparam logic [2:0] RegBeta   = 3'd3;
  localparam logic [2:0] RegGamma  = 3'd4;

  localparam int unsigned HeightLimit = 4096;

  // reaction state machine
  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StMul   = 3'b010,
    StOut   = 3'b100
  } back_state_e;
endpackage
`default_nettype wire

>>> design/rds_front.sv
`default_nettype none
// Front end: position tracking, border forcing, line stores, 3x3 window.
// Emits the 3x3 window sums of the three species for each completed window plus frame_last.
module rds_front import rds_pkg::*; #(
  parameter int unsigned MaxWidth  = 1024
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [15:0]            conc_a_i,
  input  wire logic [15:0]            conc_b_i,
  input  wire logic [15:0]            conc_c_i,
  input  wire logic                   frame_first_i,
  input  wire logic [10:0]            grid_width_i,
  input  wire logic [12:0]            grid_height_i,
  output logic                        sum_valid_o,
  input  wire logic                   sum_ready_i,
  output logic [3*(ValueBits+4)-1:0]  sum_o,
  output logic                        last_o
);
  localparam int unsigned CW = $clog2(MaxWidth + 2);
  localparam int unsigned SW = ValueBits + 4;
  localparam int unsigned CellW = 3 * ValueBits;
  localparam logic [ValueBits-1:0] One = ValueBits'(1) << (ValueBits - 1);

  // effective size
  logic [13:0] w_eff, h_eff;
  always_comb begin
    w_eff = {3'd0, grid_width_i};
    if (w_eff == 14'd0) w_eff = 14'd1;
    if (w_eff > 14'(MaxWidth)) w_eff = 14'(MaxWidth);
    h_eff = {1'b0, grid_height_i};
    if (h_eff == 14'd0) h_eff = 14'd1;
    if (h_eff > 14'(HeightLimit)) h_eff = 14'(HeightLimit);
  end

  logic [13:0] col_q, col_d, row_q, row_d;
  logic [13:0] col, row;
  logic border, fire, done, adv;
  logic [CellW-1:0] cur;
  logic [ValueBits-1:0] xa, xb, xc;
  logic busy_q;

  // one word in flight: accept and read, then write back and shift
  assign in_ready_o = !busy_q;
  assign fire = in_valid_i && in_ready_o;
  assign adv = busy_q && (!sum_valid_o || sum_ready_i);

  function automatic logic [ValueBits-1:0] sat(input logic [15:0] x);
    logic [ValueBits:0] v;
    v = (ValueBits + 1)'(x);
    if (v > {1'b0, One}) v = {1'b0, One};
    return v[ValueBits-1:0];
  endfunction

  always_comb begin
    col = frame_first_i ? 14'd0 : col_q;
    row = frame_first_i ? 14'd0 : row_q;
    if (col > w_eff + 14'd1) col = w_eff + 14'd1;
    if (row > h_eff + 14'd1) row = h_eff + 14'd1;
    border = (col == 14'd0) || (col >= w_eff + 14'd1) ||
             (row == 14'd0) || (row >= h_eff + 14'd1);
    xa = border ? '0 : sat(conc_a_i);
    xb = border ? '0 : sat(conc_b_i);
    xc = border ? '0 : sat(conc_c_i);
    cur = {xa, xb, xc};
    done = (col >= w_eff + 14'd1);
    if (done) begin
      col_d = 14'd0;
      row_d = (row >= h_eff + 14'd1) ? 14'd0 : row + 14'd1;
    end else begin
      col_d = col + 14'd1;
      row_d = row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (fire) begin
      busy_q <= 1'b1;
    end else if (adv) begin
      busy_q <= 1'b0;
    end
  end

  // line stores: registered read on accept, write-back on the next step
  logic [CellW-1:0] mem_up [MaxWidth+2];
  logic [CellW-1:0] mem_mid [MaxWidth+2];
  logic [CellW-1:0] top_q, mid_q, cur_q;
  logic [CW-1:0] idx, idx_q;
  logic emit_q, last_q;
  assign idx = col[CW-1:0];
  always_ff @(posedge clk_i) begin
    if (fire) begin
      top_q  <= mem_up[idx];
      mid_q  <= mem_mid[idx];
      cur_q  <= cur;
      idx_q  <= idx;
      emit_q <= (col >= 14'd2) && (row >= 14'd2);
      last_q <= (col == w_eff + 14'd1) && (row == h_eff + 14'd1);
    end
    if (adv) begin
      mem_up[idx_q]  <= mid_q;
      mem_mid[idx_q] <= cur_q;
    end
  end

  // window as column sums: keep per-column sums of three rows
  logic [3*(ValueBits+2)-1:0] cs0_q, cs1_q, cs2_d;
  function automatic logic [ValueBits+1:0] s3(input logic [ValueBits-1:0] p,
      input logic [ValueBits-1:0] q, input logic [ValueBits-1:0] r);
    return (ValueBits + 2)'(p) + (ValueBits + 2)'(q) + (ValueBits + 2)'(r);
  endfunction
  localparam int unsigned V = ValueBits;
  localparam int unsigned C2 = ValueBits + 2;
  assign cs2_d = {s3(top_q[3*V-1:2*V], mid_q[3*V-1:2*V], cur_q[3*V-1:2*V]),
                  s3(top_q[2*V-1:V], mid_q[2*V-1:V], cur_q[2*V-1:V]),
                  s3(top_q[V-1:0], mid_q[V-1:0], cur_q[V-1:0])};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs0_q <= '0;
      cs1_q <= '0;
    end else if (adv) begin
      cs0_q <= cs1_q;
      cs1_q <= cs2_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_o <= 1'b0;
    end else if (adv) begin
      sum_valid_o <= emit_q;
    end else if (sum_ready_i) begin
      sum_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sum_o[k*SW +: SW] <= SW'(cs0_q[k*C2 +: C2]) + SW'(cs1_q[k*C2 +: C2]) +
                             SW'(cs2_d[k*C2 +: C2]);
      end
      last_o <= last_q;
    end
  end
endmodule
`default_nettype wire

>>> design/rds_queue.sv
`default_nettype none
// Two-entry queue between front and back.
module rds_queue #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  output logic              full_o,
  input  wire logic [W-1:0] din_i,
  output logic              not_empty_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      dout_o
);
  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  assign full_o = cnt_q == 2'd2;
  assign not_empty_o = cnt_q != 2'd0;
  assign dout_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= din_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= !wp_q;
      if (pop_i && not_empty_o) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && not_empty_o);
    end
  end
endmodule
`default_nettype wire

>>> design/rds_back.sv
`default_nettype none
// Back end: /9 rounding, reaction terms, clamp, pixel packing.
module rds_back import rds_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      q_valid_i,
  output logic                           q_pop_o,
  input  wire logic [3*(ValueBits+4)-1:0] sum_i,
  input  wire logic                      last_i,
  input  wire logic [15:0]               coef_alpha_i,
  input  wire logic [15:0]               coef_beta_i,
  input  wire logic [15:0]               coef_gamma_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [15:0]                    next_a_o,
  output logic [15:0]                    next_b_o,
  output logic [15:0]                    next_c_o,
  output logic [31:0]                    pixel_word_o,
  output logic                           frame_last_o
);
  localparam int unsigned V = ValueBits;
  localparam int unsigned SW = ValueBits + 4;
  localparam int unsigned Sh = CoefFrac + ValueBits - 1;
  localparam logic [V-1:0] One = V'(1) << (V - 1);

  back_state_e st_q, st_d;
  logic [V-1:0] avg_q [3];
  logic signed [V+17:0] rate_q [3];
  logic last_q;

  assign q_pop_o = (st_q == StIdle) && q_valid_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (q_valid_i) st_d = StMul;
      StMul:  st_d = StOut;
      StOut:  if (!out_valid_o || out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // rounded average: (s+4)/9 through reciprocal multiply
  function automatic logic [V-1:0] div9(input logic [SW-1:0] s);
    logic [SW:0] t;
    logic [2*SW+4:0] p;
    logic [SW:0] qv;
    t = (SW + 1)'(s) + (SW + 1)'(4);
    p = (2*SW + 5)'(t) * (2*SW + 5)'((2**(SW + 4)) / 9 + 1);
    qv = p[SW+4 +: SW+1];
    if ((SW + 1)'(qv * 9) > t) qv = qv - 1'b1;
    return qv[V-1:0];
  endfunction

  logic signed [V+17:0] pa, pb, pc;
  logic [V-1:0] a_s, b_s, c_s;
  always_comb begin
    a_s = div9(sum_i[2*SW +: SW]);
    b_s = div9(sum_i[SW +: SW]);
    c_s = div9(sum_i[0 +: SW]);
  end

  // rate products from the latched averages
  always_comb begin
    pa = $signed({1'b0, coef_alpha_i}) * $signed({1'b0, avg_q[2]});
    pb = $signed({1'b0, coef_beta_i}) * $signed({1'b0, avg_q[0]});
    pc = $signed({1'b0, coef_gamma_i}) * $signed({1'b0, avg_q[1]});
  end

  function automatic logic [V-1:0] react(input logic [V-1:0] x,
      input logic signed [V+17:0] r);
    logic signed [2*V+19:0] pr, t, d, res;
    pr = $signed({1'b0, x}) * r;
    t = pr + ((2*V+20)'(1) <<< (Sh - 1));
    d = t >>> Sh;
    res = $signed({1'b0, x}) + d;
    if (res < 0) res = '0;
    if (res > $signed({1'b0, One})) res = (2*V+20)'(One);
    return res[V-1:0];
  endfunction

  function automatic logic [7:0] to_byte(input logic [V-1:0] x);
    logic [V+8:0] p;
    p = (V + 9)'(x) * (V + 9)'(255) + (V + 9)'(One >> 1);
    return p[V-1 +: 8];
  endfunction

  logic [V-1:0] na, nb, nc;
  always_comb begin
    na = react(avg_q[0], rate_q[0]);
    nb = react(avg_q[1], rate_q[1]);
    nc = react(avg_q[2], rate_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      out_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (st_q == StOut && st_d == StIdle) out_valid_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      avg_q[0] <= a_s;
      avg_q[1] <= b_s;
      avg_q[2] <= c_s;
      last_q <= last_i;
    end
    if (st_q == StMul) begin
      rate_q[0] <= pa - pc;
      rate_q[1] <= pb - pa;
      rate_q[2] <= pc - pb;
    end
    if (st_q == StOut && st_d == StIdle) begin
      next_a_o <= 16'(na);
      next_b_o <= 16'(nb);
      next_c_o <= 16'(nc);
      pixel_word_o <= {to_byte(na), to_byte(nb), to_byte(nc), 8'hFF};
      frame_last_o <= last_q;
    end
  end
endmodule
`default_nettype wire

>>> design/reaction_diffusion_stencil_step.sv
`default_nettype none
// Front takes one cell at a time: accept with line store read, then write-back.
// Back takes each interior result through average, rate products and reaction/clamp,
// and pops the next only after the result is registered; a two-entry queue decouples them.
// Reset clears counters, window and queue and sets config to defaults; line stores are not cleared.
module reaction_diffusion_stencil_step import rds_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] conc_a_i,
  input  wire logic [15:0] conc_b_i,
  input  wire logic [15:0] conc_c_i,
  input  wire logic        frame_first_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      next_a_o,
  output logic [15:0]      next_b_o,
  output logic [15:0]      next_c_o,
  output logic [31:0]      pixel_word_o,
  output logic             frame_last_o
);
  localparam int unsigned QW = 3 * (ValueBits + 4) + 1;

  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [15:0] alpha_q, beta_q, gamma_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 13'd1024;
      alpha_q  <= 16'd4096;
      beta_q   <= 16'd4096;
      gamma_q  <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegWidth:  width_q  <= cfg_data_i[10:0];
        RegHeight: height_q <= cfg_data_i[12:0];
        RegAlpha:  alpha_q  <= cfg_data_i;
        RegBeta:   beta_q   <= cfg_data_i;
        RegGamma:  gamma_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic             f_valid, q_full, q_ne, q_pop, f_last, qo_last;
  logic [QW-2:0]    f_sum, qo_sum;

  rds_front #(.MaxWidth(MAX_WIDTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .conc_a_i, .conc_b_i, .conc_c_i,
    .frame_first_i, .grid_width_i(width_q), .grid_height_i(height_q),
    .sum_valid_o(f_valid), .sum_ready_i(!q_full), .sum_o(f_sum), .last_o(f_last)
  );

  rds_queue #(.W(QW)) u_queue (
    .clk_i, .rst_ni, .push_i(f_valid), .full_o(q_full), .din_i({f_last, f_sum}),
    .not_empty_o(q_ne), .pop_i(q_pop), .dout_o({qo_last, qo_sum})
  );

  rds_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_ne), .q_pop_o(q_pop), .sum_i(qo_sum),
    .last_i(qo_last), .coef_alpha_i(alpha_q), .coef_beta_i(beta_q),
    .coef_gamma_i(gamma_q), .out_valid_o, .out_ready_i, .next_a_o, .next_b_o,
    .next_c_o, .pixel_word_o, .frame_last_o
  );

  // results never exceed one in value (checked on a); pixel alpha is always 0xFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> next_a_o <= 16'(1 << (ValueBits - 1))) else $error("a range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pixel_word_o[7:0] == 8'hFF) else $error("pixel alpha");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !(f_valid && q_pop && !q_ne)) else $error("queue state");
endmodule
`default_nettype wire

>>> test/rds_checker.sv
`timescale 1ns / 1ps
module rds_checker import rds_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [15:0] conc_a_i,
  input  wire logic [15:0] conc_b_i,
  input  wire logic [15:0] conc_c_i,
  input  wire logic        frame_first_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [15:0] next_a_i,
  input  wire logic [15:0] next_b_i,
  input  wire logic [15:0] next_c_i,
  input  wire logic [31:0] pixel_word_i,
  input  wire logic        frame_last_i,
  output int               n_fail_o,
  output int               n_pending_o,
  output int               n_results_o
);

  localparam longint unsigned One = 32768;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } conc_t;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [31:0] pix;
    logic        last;
  } update_t;

  conc_t       row_above [MAX_WIDTH+2];
  conc_t       row_mid   [MAX_WIDTH+2];
  conc_t       win [3][3];
  int unsigned col_cnt, row_cnt;
  int unsigned grid_w, grid_h;
  longint      alpha, beta, gamma;
  update_t     expected_q[$];

  // apply one reaction term and clamp to [0,1]
  function automatic logic [15:0] react_clamp(longint x, longint rate);
    longint d;
    longint r;
    d = (x * rate + (longint'(1) <<< 26)) >>> 27;
    r = x + d;
    if (r < 0) r = 0;
    if (r > One) r = One;
    return r[15:0];
  endfunction

  function automatic logic [7:0] byte_of(logic [15:0] x);
    longint unsigned t;
    t = (longint'(x) * 255 + One / 2) >> 15;
    return t[7:0];
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
    n_fail_o++;
  endtask

  // advance window and line stores for one accepted word
  task automatic predict_word();
    int unsigned w, h, col, row, sa, sb, sc;
    bit          border;
    conc_t       cur, top, mid;
    longint      av_a, av_b, av_c;
    update_t     u;
    w = grid_w; h = grid_h;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h == 0) h = 1;
    if (h > HeightLimit) h = HeightLimit;
    if (frame_first_i) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    col = (col_cnt > w + 1) ? w + 1 : col_cnt;
    row = (row_cnt > h + 1) ? h + 1 : row_cnt;
    border = (col == 0) || (col >= w + 1) || (row == 0) || (row >= h + 1);
    cur.a = border ? 16'd0 : (conc_a_i > One ? 16'(One) : conc_a_i);
    cur.b = border ? 16'd0 : (conc_b_i > One ? 16'(One) : conc_b_i);
    cur.c = border ? 16'd0 : (conc_c_i > One ? 16'(One) : conc_c_i);
    top = row_above[col];
    mid = row_mid[col];
    row_above[col] = mid;
    row_mid[col] = cur;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = cur;
    if (col >= 2 && row >= 2) begin
      sa = 0; sb = 0; sc = 0;
      for (int i = 0; i < 9; i++) begin
        sa += win[i/3][i%3].a;
        sb += win[i/3][i%3].b;
        sc += win[i/3][i%3].c;
      end
      av_a = (sa + 4) / 9;
      av_b = (sb + 4) / 9;
      av_c = (sc + 4) / 9;
      u.a = react_clamp(av_a, alpha * av_c - gamma * av_b);
      u.b = react_clamp(av_b, beta * av_a - alpha * av_c);
      u.c = react_clamp(av_c, gamma * av_b - beta * av_a);
      u.pix = {byte_of(u.a), byte_of(u.b), byte_of(u.c), 8'hFF};
      u.last = (col == w + 1) && (row == h + 1);
      expected_q.push_back(u);
    end
    if (col >= w + 1) begin
      col_cnt = 0;
      row_cnt = (row >= h + 1) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
      row_cnt = row;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    update_t u;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH + 2; i++) begin
        row_above[i] = '0;
        row_mid[i] = '0;
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      col_cnt = 0; row_cnt = 0;
      grid_w = 1024; grid_h = 1024;
      alpha = 4096; beta = 4096; gamma = 4096;
      expected_q.delete();
      n_fail_o = 0;
      n_pending_o = 0;
      n_results_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegWidth:  grid_w = cfg_data_i[10:0];
          RegHeight: grid_h = cfg_data_i[12:0];
          RegAlpha:  alpha = cfg_data_i;
          RegBeta:   beta = cfg_data_i;
          RegGamma:  gamma = cfg_data_i;
          default: ;
        endcase
      end
      // compare before predicting so a new expectation is never matched early
      if (out_valid_i && out_ready_i) begin
        n_results_o++;
        if (expected_q.size() == 0) begin
          report("unexpected word", pixel_word_i, 32'h0);
        end else begin
          u = expected_q.pop_front();
          if (next_a_i !== u.a) report("next_a", next_a_i, u.a);
          if (next_b_i !== u.b) report("next_b", next_b_i, u.b);
          if (next_c_i !== u.c) report("next_c", next_c_i, u.c);
          if (pixel_word_i !== u.pix) report("pixel_word", pixel_word_i, u.pix);
          if (frame_last_i !== u.last) report("frame_last", frame_last_i, u.last);
        end
      end
      if (in_valid_i && in_ready_i) predict_word();
      n_pending_o = expected_q.size();
    end
  end

endmodule

>>> test/tb_reaction_diffusion_stencil_step.sv
`timescale 1ns / 1ps
module tb_reaction_diffusion_stencil_step import rds_pkg::*;;

  localparam int CycleLimit = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = RegWidth;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] conc_a_i = '0, conc_b_i = '0, conc_c_i = '0;
  logic        frame_first_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] next_a_o, next_b_o, next_c_o;
  logic [31:0] pixel_word_o;
  logic        frame_last_o;

  int n_fail, n_pending, n_results;
  int cycles = 0;
  int n_words = 0;
  int rnd_words = 0;
  int n_settings = 0;
  int mode = 0;  // 0: sender 19%, receiver 49% idle; 1: sender 49%, receiver 19% idle; 2: no random idling
  bit hold_go = 1'b0;
  bit hold_used = 1'b0;
  int hold_cnt = 0;

  always #10 clk_i = ~clk_i;

  reaction_diffusion_stencil_step i_dut (.*);

  rds_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .conc_a_i, .conc_b_i, .conc_c_i,
    .frame_first_i, .out_valid_i(out_valid_o), .out_ready_i,
    .next_a_i(next_a_o), .next_b_i(next_b_o), .next_c_i(next_c_o),
    .pixel_word_i(pixel_word_o), .frame_last_i(frame_last_o),
    .n_fail_o(n_fail), .n_pending_o(n_pending), .n_results_o(n_results)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= (mode == 0 ? 49 : mode == 1 ? 19 : 0));
    end
  end

  // size of the current random frame, as last written
  int cur_w, cur_h;
  always @(posedge clk_i) begin
    if (cfg_we_i && cfg_index_i == RegWidth) cur_w <= cfg_data_i;
    if (cfg_we_i && cfg_index_i == RegHeight) cur_h <= cfg_data_i;
  end

  function automatic int i_cfg_w();
    return (cur_w == 0) ? 1 : (cur_w > 1024 ? 1024 : cur_w);
  endfunction

  function automatic int i_cfg_h();
    return (cur_h == 0) ? 1 : (cur_h > 4096 ? 4096 : cur_h);
  endfunction

  function automatic logic [15:0] rand_conc();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'($urandom());
    if (r < 30) return $urandom_range(1) ? 16'd32768 : 16'd0;
    return 16'($urandom_range(32768));
  endfunction

  // offer one word and return at the falling edge after acceptance
  task automatic send_word(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic ff);
    while ($urandom_range(99) < (mode == 0 ? 19 : mode == 1 ? 49 : 0)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    conc_a_i <= a;
    conc_b_i <= b;
    conc_c_i <= c;
    frame_first_i <= ff;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    n_words++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (n_pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_config(int w, int h, int al, int be, int ga);
    cfg_we_i <= 1'b1;
    cfg_index_i <= RegWidth;  cfg_data_i <= 16'(w & 16'h7FF);  @(negedge clk_i);
    cfg_index_i <= RegHeight; cfg_data_i <= 16'(h & 16'h1FFF); @(negedge clk_i);
    cfg_index_i <= RegAlpha;  cfg_data_i <= 16'(al); @(negedge clk_i);
    cfg_index_i <= RegBeta;   cfg_data_i <= 16'(be); @(negedge clk_i);
    cfg_index_i <= RegGamma;  cfg_data_i <= 16'(ga); @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    n_settings++;
  endtask

  // stream a padded frame, sometimes cut short, with rare stray frame starts
  task automatic send_frame(int w, int h, int n_max);
    int total;
    total = (w + 2) * (h + 2);
    if (n_max > 0 && n_max < total) total = n_max;
    else if ($urandom_range(9) == 0) total = $urandom_range(1, total);
    for (int i = 0; i < total; i++) begin
      send_word(rand_conc(), rand_conc(), rand_conc(), (i == 0) || ($urandom_range(199) == 0));
    end
  endtask

  function automatic int rand_coef();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 30) return 65535;
    if (r < 60) return $urandom_range(65535);
    return $urandom_range(8192);
  endfunction

  initial begin
    int w, h;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // single interior cell: borders full scale (ignored), center saturates a
    write_config(1, 1, 4096, 4096, 4096);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_word(16'hFFFF, 16'd32768, 16'd0, 1'b0);
      else send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, i == 0);
    end
    wait_idle();
    // two interior cells, extreme coefficients
    write_config(2, 1, 65535, 0, 65535);
    for (int i = 0; i < 12; i++) begin
      send_word(i[0] ? 16'd32768 : 16'd0, i[1] ? 16'd32768 : 16'd1,
                16'd32768 - 16'(i), i == 0);
    end
    wait_idle();

    // random settings and frames
    while (rnd_words < 1080) begin
      mode = (rnd_words < 360) ? 0 : (rnd_words < 720) ? 1 : 2;
      if ($urandom_range(4) == 0) w = $urandom_range(9, 40);
      else w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      write_config(w, h, rand_coef(), rand_coef(), rand_coef());
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        if (mode == 2 && !hold_go) hold_go = 1'b1;
        w = n_words;
        send_frame(i_cfg_w(), i_cfg_h(), 0);
        rnd_words += n_words - w;
      end
      wait_idle();
    end

    // mid-frame shrink: counters past the new end
    write_config(6, 4, rand_coef(), rand_coef(), rand_coef());
    send_frame(6, 4, 24);
    wait_idle();
    write_config(3, 1, rand_coef(), rand_coef(), rand_coef());
    for (int i = 0; i < 20; i++) send_word(rand_conc(), rand_conc(), rand_conc(), 1'b0);
    wait_idle();
    // height beyond the limit, then at the limit (partial frames)
    write_config(1, 8191, 4096, 4096, 4096);
    send_frame(1, 4096, 30);
    wait_idle();
    write_config(1, 4096, 65535, 65535, 65535);
    send_frame(1, 4096, 15);
    wait_idle();
    // zero sizes act as one
    write_config(0, 0, 0, 0, 0);
    send_frame(1, 1, 9);
    wait_idle();
    // width beyond the line store saturates to full width (partial frame)
    write_config(2047, 1, rand_coef(), rand_coef(), rand_coef());
    send_frame(1024, 1, 60);
    wait_idle();

    repeat (50) @(negedge clk_i);
    $display("covered %0d input words, %0d results, %0d register settings",
             n_words, n_results, n_settings);
    $display("size extremes, coefficient extremes, stray frame starts and a long stall");
    if (n_fail == 0 && n_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
design/rds_pkg.sv
design/rds_front.sv
design/rds_queue.sv
design/rds_back.sv
design/reaction_diffusion_stencil_step.sv
test/rds_checker.sv
test/tb_reaction_diffusion_stencil_step.sv
